### rtl/mrpb_pkg.sv
// Package for the masked ROP4 pixel blit: sizes, register indexes and ROP helpers.
`timescale 1ns / 1ps

package mrpb_pkg;

  // Pixel and tile store geometry
  localparam int PIXEL_BITS  = 32;
  localparam int TILE_SIDE   = 8;
  localparam int STORE_DEPTH = TILE_SIDE * TILE_SIDE;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int COORD_W     = $clog2(TILE_SIDE);

  // Field widths fixed by the interface
  localparam int ROP_W      = 8;
  localparam int SIZE_W     = 4;
  localparam int START_W    = 3;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int DATA_W     = 32;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FORE_ROP     = 4'd0,
    REG_BACK_ROP     = 4'd1,
    REG_SOLID_COLOR  = 4'd2,
    REG_TILE_ENABLE  = 4'd3,
    REG_TILE_WIDTH   = 4'd4,
    REG_TILE_HEIGHT  = 4'd5,
    REG_TILE_X_START = 4'd6,
    REG_TILE_Y_START = 4'd7
  } cfg_reg_e;

  // Request kinds
  localparam logic OP_TILE_WRITE = 1'b0;
  localparam logic OP_PIXEL      = 1'b1;

  // Reset values of the registers
  localparam logic [ROP_W-1:0]  FORE_ROP_RST = 8'hCC;
  localparam logic [ROP_W-1:0]  BACK_ROP_RST = 8'hAA;
  localparam logic [SIZE_W-1:0] TILE_SIZE_RST = SIZE_W'(TILE_SIDE);

  // Tile size clamped to 1..TILE_SIDE
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] r;
    if (v == '0) begin
      r = SIZE_W'(1);
    end else if (v > SIZE_W'(TILE_SIDE)) begin
      r = SIZE_W'(TILE_SIDE);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Ternary raster op: every bit indexes the ROP3 code with {P,S,D}
  function automatic logic [PIXEL_BITS-1:0] apply_rop(input logic [ROP_W-1:0] rop,
                                                     input logic [PIXEL_BITS-1:0] p,
                                                     input logic [PIXEL_BITS-1:0] s,
                                                     input logic [PIXEL_BITS-1:0] d);
    logic [PIXEL_BITS-1:0] r;
    r = '0;
    for (int i = 0; i < PIXEL_BITS; i++) begin
      r[i] = rop[{p[i], s[i], d[i]}];
    end
    return r;
  endfunction

endpackage

### rtl/masked_rop4_pixel_blit.sv
// Masked ROP4 pixel blit engine: tile store, tile walker and ROP3 datapath.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------------------
//  in      | sink      | in_valid_i / in_stall_o  | op, tile_index/value, mask, src, dst,
//          |           |                          | row_end, rect_start
//  out     | source    | out_valid_o / out_stall_i| result_pixel, is_tile_write
//  cfg     | sink      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One request per clock while the input is not stalled; a request passes through the stage 1
// register and then the output register before its result is valid.
// The tile store is a single-port-write, single-port-read synchronous RAM read in the
// accept cycle; the ROP and pattern select run in the stage after it.
// Reset clears the tile walker, the registers and the pipeline valids; the tile store
// is not cleared. A stalled output holds; input stalls only once both stages are full.
`timescale 1ns / 1ps

module masked_rop4_pixel_blit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             op_i,
  input  logic [mrpb_pkg::STORE_AW-1:0]    tile_index_i,
  input  logic [mrpb_pkg::DATA_W-1:0]      tile_value_i,
  input  logic                             mask_bit_i,
  input  logic [mrpb_pkg::DATA_W-1:0]      source_pixel_i,
  input  logic [mrpb_pkg::DATA_W-1:0]      dest_pixel_i,
  input  logic                             row_end_i,
  input  logic                             rect_start_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [mrpb_pkg::DATA_W-1:0]      result_pixel_o,
  output logic                             is_tile_write_o,
  // configuration channel
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mrpb_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mrpb_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import mrpb_pkg::*;

  // configuration registers
  logic [ROP_W-1:0]   fore_rop_q, back_rop_q;
  logic [DATA_W-1:0]  solid_color_q;
  logic               tile_enable_q;
  logic [SIZE_W-1:0]  tile_width_q, tile_height_q;
  logic [START_W-1:0] tile_x_start_q, tile_y_start_q;

  // tile walker
  logic [COORD_W-1:0] tile_col_q, tile_col_d;
  logic [COORD_W-1:0] tile_row_q, tile_row_d;

  // pipeline
  logic               s1_valid_q;
  logic               s1_tile_wr_q, s1_mbit_q, s1_use_tile_q;
  logic [DATA_W-1:0]  s1_src_q, s1_dst_q;
  logic [DATA_W-1:0]  rd_data_q;
  logic               out_valid_q, out_tile_q;
  logic [DATA_W-1:0]  out_pixel_q;

  logic [DATA_W-1:0]  tile_mem [STORE_DEPTH];

  logic               in_accept, out_free, s1_move;
  logic               pix_accept, wr_accept;
  logic [SIZE_W-1:0]  eff_w, eff_h;
  logic [SIZE_W-1:0]  start_col, start_row;
  logic [SIZE_W-1:0]  col_sel, row_sel, col_cur, row_cur;
  logic [SIZE_W-1:0]  col_inc, row_inc;
  logic [STORE_AW-1:0] rd_addr;
  logic [ROP_W-1:0]   s1_rop;
  logic [DATA_W-1:0]  s1_pattern, s1_result;

  // handshake
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_move     = s1_valid_q && out_free;
  assign in_stall_o  = s1_valid_q && !out_free;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign pix_accept  = in_accept && (op_i == OP_PIXEL);
  assign wr_accept   = in_accept && (op_i == OP_TILE_WRITE);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fore_rop_q     <= FORE_ROP_RST;
      back_rop_q     <= BACK_ROP_RST;
      solid_color_q  <= '0;
      tile_enable_q  <= 1'b0;
      tile_width_q   <= TILE_SIZE_RST;
      tile_height_q  <= TILE_SIZE_RST;
      tile_x_start_q <= '0;
      tile_y_start_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_FORE_ROP:     fore_rop_q     <= cfg_data_i[ROP_W-1:0];
        REG_BACK_ROP:     back_rop_q     <= cfg_data_i[ROP_W-1:0];
        REG_SOLID_COLOR:  solid_color_q  <= cfg_data_i[DATA_W-1:0];
        REG_TILE_ENABLE:  tile_enable_q  <= cfg_data_i[0];
        REG_TILE_WIDTH:   tile_width_q   <= cfg_data_i[SIZE_W-1:0];
        REG_TILE_HEIGHT:  tile_height_q  <= cfg_data_i[SIZE_W-1:0];
        REG_TILE_X_START: tile_x_start_q <= cfg_data_i[START_W-1:0];
        REG_TILE_Y_START: tile_y_start_q <= cfg_data_i[START_W-1:0];
        default: ;
      endcase
    end
  end

  // tile position for this pixel and its successor
  always_comb begin
    eff_w     = eff_size(tile_width_q);
    eff_h     = eff_size(tile_height_q);
    start_col = (SIZE_W'(tile_x_start_q) < eff_w) ? SIZE_W'(tile_x_start_q) : '0;
    start_row = (SIZE_W'(tile_y_start_q) < eff_h) ? SIZE_W'(tile_y_start_q) : '0;
    // rect start reloads, then an out-of-range position wraps to zero
    col_sel   = rect_start_i ? start_col : SIZE_W'(tile_col_q);
    row_sel   = rect_start_i ? start_row : SIZE_W'(tile_row_q);
    col_cur   = (col_sel >= eff_w) ? '0 : col_sel;
    row_cur   = (row_sel >= eff_h) ? '0 : row_sel;
    rd_addr   = STORE_AW'(row_cur[COORD_W-1:0] * TILE_SIDE)
              + STORE_AW'(col_cur[COORD_W-1:0]);
    col_inc   = col_cur + SIZE_W'(1);
    row_inc   = row_cur + SIZE_W'(1);
    tile_col_d = (col_inc >= eff_w) ? '0 : col_inc[COORD_W-1:0];
    tile_row_d = row_cur[COORD_W-1:0];
    if (row_end_i) begin
      tile_row_d = (row_inc >= eff_h) ? '0 : row_inc[COORD_W-1:0];
      tile_col_d = start_col[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_col_q <= '0;
      tile_row_q <= '0;
    end else if (pix_accept) begin
      tile_col_q <= tile_col_d;
      tile_row_q <= tile_row_d;
    end
  end

  // tile store: write on tile requests, read on pixel requests
  always_ff @(posedge clk_i) begin
    if (wr_accept) begin
      tile_mem[tile_index_i] <= tile_value_i;
    end
    if (pix_accept) begin
      rd_data_q <= tile_mem[rd_addr];
    end
  end

  // stage 1 valid and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // stage 1 payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_tile_wr_q  <= (op_i == OP_TILE_WRITE);
      s1_mbit_q     <= mask_bit_i;
      s1_use_tile_q <= tile_enable_q;
      s1_src_q      <= source_pixel_i;
      s1_dst_q      <= dest_pixel_i;
    end
  end

  // ROP3 datapath
  always_comb begin
    s1_rop     = s1_mbit_q ? fore_rop_q : back_rop_q;
    s1_pattern = s1_use_tile_q ? rd_data_q : solid_color_q;
    s1_result  = DATA_W'(apply_rop(s1_rop, s1_pattern[PIXEL_BITS-1:0],
                                   s1_src_q[PIXEL_BITS-1:0], s1_dst_q[PIXEL_BITS-1:0]));
    if (s1_tile_wr_q) begin
      s1_result = '0;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_pixel_q <= s1_result;
      out_tile_q  <= s1_tile_wr_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_pixel_o  = out_pixel_q;
  assign is_tile_write_o = out_tile_q;

  // a tile write acknowledgement never carries pixel data
  a_tile_ack_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_tile_write_o |-> result_pixel_o == '0)
    else $error("tile write result with nonzero pixel");

  // input stalls only with both stages occupied
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with a free stage");

  // an accepted request occupies stage 1 in the next cycle
  a_accept_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted request lost before stage 1");

  // a request leaving stage 1 lands in the output register
  a_move_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_move |=> out_valid_q)
    else $error("stage 1 request lost before output");

endmodule
